[design/tguq_pkg.sv]
// ----------------------------------------------------------------------------
// Thermal grid upscale quantizer: shared package
// Grid geometry, sample and level types, register indexes, the mapping
// control bundle and the dither pattern lookup.
// ----------------------------------------------------------------------------
package tguq_pkg;

    localparam int GRID_WIDTH   = 8;
    localparam int GRID_LAST    = GRID_WIDTH - 1;
    localparam int CENTRE_COORD = GRID_WIDTH / 2;
    localparam int ADDR_W       = 6;
    localparam int SAMPLE_W     = 11;
    localparam int COORD_W      = 6;
    localparam int OUT_ROWS     = 16;
    localparam int ROW_W        = 4;
    localparam int COL_W        = 4;
    localparam int LEVEL_W      = 3;
    localparam int DEG_W        = 8;
    localparam int DEGC_W       = 9;
    localparam int SPAN_W       = 10;
    localparam int MULT_W       = 11;
    localparam int PATTERN_W    = 16;
    localparam int CFG_IDX_W    = 2;

    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(OUT_ROWS - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DEGC_W-1:0]   t_degc;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [COORD_W-1:0]         t_coord;
    typedef logic [DEG_W-1:0]           t_deg;
    typedef logic [LEVEL_W-1:0]         t_level;
    typedef logic [PATTERN_W-1:0]       t_pattern;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_LOW        = 2'd0,
        CFG_MAP_HIGH_FLOOR = 2'd1,
        CFG_ALERT_LEVEL    = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic              empty;
        t_degc             low;
        logic [MULT_W-1:0] mult1;
        logic [MULT_W-1:0] mult2;
        logic [MULT_W-1:0] mult3;
        logic [MULT_W-1:0] mult4;
    } t_map_cfg;

    function automatic t_coord clamp_coord(input t_coord g);
        return (g > t_coord'(GRID_LAST)) ? t_coord'(GRID_LAST) : g;
    endfunction

    function automatic t_addr cell_addr(input t_coord gc, input t_coord gr);
        int sum;
        sum = int'(gr) + int'(gc) * GRID_WIDTH;
        return t_addr'(sum);
    endfunction

    function automatic t_pattern dither_word(input t_level lvl);
        t_pattern word;
        unique case (lvl)
            3'd0:    word = 16'h0000;
            3'd1:    word = 16'h1080;
            3'd2:    word = 16'h1428;
            3'd3:    word = 16'h7ebd;
            default: word = 16'hffff;
        endcase
        return word;
    endfunction

endpackage

[design/tguq_sample_ram.sv]
// ----------------------------------------------------------------------------
// Thermal grid upscale quantizer: sample memory
// One write port and two read ports over the grid samples, with the read
// data registered in the cycle after the address.
// ----------------------------------------------------------------------------
module tguq_sample_ram
    import tguq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_we,
    input  t_addr   i_waddr,
    input  t_sample i_wdata,
    input  t_addr   i_raddr_a,
    input  t_addr   i_raddr_b,
    output t_sample o_rdata_a,
    output t_sample o_rdata_b
);

    t_sample r_mem [2**ADDR_W];
    t_sample r_rdata_a;
    t_sample r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[design/tguq_level_map.sv]
// ----------------------------------------------------------------------------
// Thermal grid upscale quantizer: level mapping
// Maps a whole-degree pixel value onto heat levels 0 to 4 by comparing four
// times its offset from the low bound against multiples of the span, and
// selects the matching dither pattern.
// ----------------------------------------------------------------------------
module tguq_level_map
    import tguq_pkg::*;
(
    input  t_deg     i_deg,
    input  t_map_cfg i_cfg,
    output t_level   o_level,
    output t_pattern o_pattern
);

    logic signed [SPAN_W-1:0] diff;
    logic [MULT_W-1:0]        num;
    logic                     positive;
    t_level                   level;

    assign diff     = $signed({2'b00, i_deg}) - $signed({i_cfg.low[DEGC_W-1], i_cfg.low});
    assign num      = {diff[SPAN_W-2:0], 2'b00};
    assign positive = !diff[SPAN_W-1] && (diff != '0);

    always_comb begin
        if (i_cfg.empty) begin
            level = diff[SPAN_W-1] ? LEVEL_MIN : LEVEL_MAX;
        end else if (!positive) begin
            level = LEVEL_MIN;
        end else begin
            priority if (num >= i_cfg.mult4) begin
                level = LEVEL_MAX;
            end else if (num >= i_cfg.mult3) begin
                level = 3'd3;
            end else if (num >= i_cfg.mult2) begin
                level = 3'd2;
            end else if (num >= i_cfg.mult1) begin
                level = 3'd1;
            end else begin
                level = LEVEL_MIN;
            end
        end
    end

    assign o_level   = level;
    assign o_pattern = dither_word(level);

endmodule

[design/thermal_grid_upscale_quantizer.sv]
// ----------------------------------------------------------------------------
// Thermal grid upscale quantizer
// Holds an 8x8 thermal frame in a sample memory with a running maximum and
// renders one 16-pixel output column per request as quantized heat levels.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Contents
//  input     in         i_in_valid / o_in_stall    op, sample index, temp, column
//  output    out        o_out_valid / i_out_stall  column, row, level, pattern,
//                                                  alert flag, last
//  config    in         i_cfg_valid / o_cfg_ready  register index, data
//
//  A load request produces no pixel and leaves the sequencer idle.
//  A render request fetches the centre sample and the span in its setup and
//  centre steps, then steps per row through the memory read, the averaging
//  and the level mapping, through the two read ports of the sample memory.
//  Output stall holds the sequencer in its emit step while a pixel is pending.
//  Reset clears the frame maximum and the sequencer and sets the mapping and
//  alert registers to their defaults; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module thermal_grid_upscale_quantizer
    import tguq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [ADDR_W-1:0]    i_sample_index,
    input  logic signed [10:0]   i_temperature,
    input  logic [COL_W-1:0]     i_column,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [COL_W-1:0]     o_out_column,
    output logic [ROW_W-1:0]     o_out_row,
    output logic [LEVEL_W-1:0]   o_level,
    output logic [PATTERN_W-1:0] o_pattern,
    output logic                 o_over_level,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_W-1:0]  i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SETUP  = 6'b000010,
        S_CENTRE = 6'b000100,
        S_READ   = 6'b001000,
        S_DEG    = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   r_col;
    t_sample            r_frame_max;
    t_degc              r_map_low;
    t_degc              r_map_high_floor;
    t_sample            r_alert_level;
    logic signed [SPAN_W-1:0] r_span;
    t_map_cfg           r_map;
    logic               r_over;
    t_deg               r_deg;

    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_column;
    logic [ROW_W-1:0]   r_out_row;
    t_level             r_out_level;
    t_pattern           r_out_pattern;
    logic               r_out_over;
    logic               r_out_last;

    logic               in_accept;
    logic               load_accept;
    logic               emit_go;
    t_addr              raddr_a;
    t_addr              raddr_b;
    t_sample            rdata_a;
    t_sample            rdata_b;
    t_coord             gc;
    t_coord             gc_next;
    t_coord             gr;
    t_coord             gr_next;
    logic [COL_W:0]     col_inc;
    logic               fm_above;
    t_sample            fm_bias;
    t_degc              upper;
    logic signed [SPAN_W-1:0] span;
    logic signed [SAMPLE_W:0] pair_sum;
    t_deg               deg_single;
    t_deg               deg_pair;
    logic [MULT_W-1:0]  mult1;
    logic [MULT_W-1:0]  mult2;
    t_level             map_level;
    t_pattern           map_pattern;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign load_accept = in_accept && (i_op == OP_LOAD);
    assign emit_go     = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // Read addressing for the current row.
    assign col_inc = {1'b0, r_col} + 5'd1;
    assign gc      = clamp_coord(t_coord'(r_col[COL_W-1:1]));
    assign gc_next = clamp_coord(t_coord'(col_inc[COL_W:1]));
    assign gr      = clamp_coord(t_coord'(r_row[ROW_W-1:1]));
    assign gr_next = clamp_coord(gr + t_coord'(1));

    always_comb begin
        if (r_state == S_SETUP) begin
            raddr_a = cell_addr(t_coord'(CENTRE_COORD), t_coord'(CENTRE_COORD));
            raddr_b = raddr_a;
        end else begin
            raddr_a = cell_addr(gc, gr);
            raddr_b = r_col[0] ? cell_addr(gc_next, gr) : cell_addr(gc, gr_next);
        end
    end

    tguq_sample_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (load_accept),
        .i_waddr   (i_sample_index),
        .i_wdata   (i_temperature),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Upper mapping bound and span.
    assign fm_above = r_frame_max > $signed({r_map_high_floor, 2'b00});
    assign fm_bias  = r_frame_max + (r_frame_max[SAMPLE_W-1] ? 11'sd3 : 11'sd0);
    assign upper    = fm_above ? t_degc'(fm_bias[SAMPLE_W-1:2]) : r_map_high_floor;
    assign span     = $signed({upper[DEGC_W-1], upper})
                    - $signed({r_map_low[DEGC_W-1], r_map_low});
    assign mult1    = MULT_W'(unsigned'(r_span[SPAN_W-2:0]));
    assign mult2    = {1'b0, r_span[SPAN_W-2:0], 1'b0};

    // Pixel value in whole degrees.
    assign pair_sum   = $signed({rdata_a[SAMPLE_W-1], rdata_a})
                      + $signed({rdata_b[SAMPLE_W-1], rdata_b});
    assign deg_single = rdata_a[SAMPLE_W-1] ? '0 : t_deg'(rdata_a[SAMPLE_W-2:2]);
    assign deg_pair   = pair_sum[SAMPLE_W] ? '0 : t_deg'(pair_sum[SAMPLE_W-1:3]);

    tguq_level_map u_map (
        .i_deg     (r_deg),
        .i_cfg     (r_map),
        .o_level   (map_level),
        .o_pattern (map_pattern)
    );

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_op == OP_RENDER)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP:  n_state = S_CENTRE;
            S_CENTRE: n_state = S_READ;
            S_READ:   n_state = S_DEG;
            S_DEG:    n_state = S_EMIT;
            S_EMIT: begin
                if (emit_go) begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = (r_row == ROW_LAST) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_row   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_row            <= '0;
            r_frame_max      <= '0;
            r_map_low        <= 9'sd20;
            r_map_high_floor <= 9'sd24;
            r_alert_level    <= 11'sd128;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            if (load_accept && ((i_sample_index == '0) || (i_temperature > r_frame_max))) begin
                r_frame_max <= i_temperature;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MAP_LOW:        r_map_low        <= t_degc'(i_cfg_data[DEGC_W-1:0]);
                    CFG_MAP_HIGH_FLOOR: r_map_high_floor <= t_degc'(i_cfg_data[DEGC_W-1:0]);
                    CFG_ALERT_LEVEL:    r_alert_level    <= t_sample'(i_cfg_data);
                    default: ;
                endcase
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col <= i_column;
        end
        if (r_state == S_SETUP) begin
            r_span      <= span;
            r_map.empty <= span[SPAN_W-1] || (span == '0);
            r_map.low   <= r_map_low;
        end
        if (r_state == S_CENTRE) begin
            r_over      <= (rdata_a >= r_alert_level);
            r_map.mult1 <= mult1;
            r_map.mult2 <= mult2;
            r_map.mult3 <= mult1 + mult2;
            r_map.mult4 <= {r_span[SPAN_W-2:0], 2'b00};
        end
        if (r_state == S_DEG) begin
            r_deg <= (!r_col[0] && !r_row[0]) ? deg_single : deg_pair;
        end
        if (emit_go) begin
            r_out_column  <= r_col;
            r_out_row     <= r_row;
            r_out_level   <= map_level;
            r_out_pattern <= map_pattern;
            r_out_over    <= r_over;
            r_out_last    <= (r_row == ROW_LAST);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_column = r_out_column;
    assign o_out_row    = r_out_row;
    assign o_level      = r_out_level;
    assign o_pattern    = r_out_pattern;
    assign o_over_level = r_out_over;
    assign o_last       = r_out_last;

    a_idle_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_row == '0))
        else $error("Row counter not cleared while idle.");

    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_out_valid) |-> r_out_last)
        else $error("Idle with an unfinished column pending.");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_level <= LEVEL_MAX))
        else $error("Heat level out of range.");

    a_render_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_op == OP_RENDER)) |=> (r_state == S_SETUP))
        else $error("Render request did not start the sequencer.");

    a_column_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && (r_row == ROW_LAST)) |=> ((r_state == S_IDLE) && r_out_valid && r_out_last))
        else $error("Final row did not close the column.");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the thermal grid upscale quantizer
// Loads thermal frames of several shapes, requests column renders under a
// range of mapping settings, and checks every pixel against an in-bench
// prediction of the column, row, level, dither word, alert flag and last
// flag, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
    import tguq_pkg::*;

    localparam int CELLS        = GRID_WIDTH * GRID_WIDTH;
    localparam int SETTLE_TICKS = 60;
    localparam int FRAME_ITEMS  = 72;

    typedef struct {
        logic [COL_W-1:0]     column;
        logic [ROW_W-1:0]     row;
        logic [LEVEL_W-1:0]   level;
        logic [PATTERN_W-1:0] pattern;
        logic                 over;
        logic                 last;
    } t_pixel;

    class heat_map_scoreboard;
        t_sample        grid[CELLS];
        int             peak;
        int             low_deg;
        int             floor_deg;
        int             alert_q;
        logic [15:0]    shades[5];
        t_pixel         expected_pixels[$];
        int             errors;

        function new();
            peak      = 0;
            low_deg   = 20;
            floor_deg = 24;
            alert_q   = 128;
            errors    = 0;
            shades    = '{16'h0000, 16'h1080, 16'h1428, 16'h7ebd, 16'hffff};
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void set_reg(t_cfg_index idx, logic [10:0] data);
            case (idx)
                CFG_MAP_LOW:        low_deg = $signed(data[8:0]);
                CFG_MAP_HIGH_FLOOR: floor_deg = $signed(data[8:0]);
                CFG_ALERT_LEVEL:    alert_q = $signed(data);
                default: ;
            endcase
        endfunction

        function int edge_clamp(int g);
            return (g > GRID_LAST) ? GRID_LAST : g;
        endfunction

        function int sample_at(int gc, int gr);
            return grid[(gr + gc * GRID_WIDTH) % CELLS];
        endfunction

        function void note_request(logic op, logic [5:0] idx, t_sample temp,
                                   logic [3:0] col);
            int     t;
            int     upper;
            int     span;
            int     centre;
            int     gc;
            int     gr;
            int     deg;
            int     lvl;
            int     c;
            t_pixel px;
            if (op == OP_LOAD) begin
                t = temp;
                grid[idx] = temp;
                if (idx == 0 || t > peak) begin
                    peak = t;
                end
                return;
            end
            c = col;
            upper = (peak > floor_deg * 4) ? peak / 4 : floor_deg;
            span = upper - low_deg;
            centre = sample_at(CENTRE_COORD, CENTRE_COORD);
            gc = edge_clamp(c / 2);
            for (int r = 0; r < OUT_ROWS; r++) begin
                gr = edge_clamp(r / 2);
                if (c % 2 == 0 && r % 2 == 0) begin
                    deg = sample_at(gc, gr);
                    deg = (deg < 0) ? 0 : deg / 4;
                end else begin
                    if (c % 2 == 0) begin
                        deg = sample_at(gc, gr) + sample_at(gc, edge_clamp(gr + 1));
                    end else begin
                        deg = sample_at(gc, gr) + sample_at(edge_clamp((c + 1) / 2), gr);
                    end
                    deg = (deg < 0) ? 0 : deg / 8;
                end
                if (span <= 0) begin
                    lvl = (deg >= low_deg) ? 4 : 0;
                end else begin
                    lvl = (deg - low_deg) * 4 / span;
                    if (lvl > 4) lvl = 4;
                    if (lvl < 0) lvl = 0;
                end
                px.column  = col;
                px.row     = 4'(r);
                px.level   = 3'(lvl);
                px.pattern = shades[lvl];
                px.over    = (centre >= alert_q);
                px.last    = (r == OUT_ROWS - 1);
                expected_pixels.push_back(px);
            end
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_pixel(logic [3:0] col, logic [3:0] row, logic [2:0] level,
                                  logic [15:0] pattern, logic over, logic last);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t ns: pixel with no request outstanding, column %0d row %0d",
                         $time, col, row);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("column", 16'(want.column), 16'(col));
            compare_field("row", 16'(want.row), 16'(row));
            compare_field("level", 16'(want.level), 16'(level));
            compare_field("pattern", want.pattern, pattern);
            compare_field("over_level", 16'(want.over), 16'(over));
            compare_field("last", 16'(want.last), 16'(last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_op;
    logic [ADDR_W-1:0]    in_sample_index;
    logic signed [10:0]   in_temperature;
    logic [COL_W-1:0]     in_column;
    logic                 out_stall;
    logic                 cfg_valid;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;

    wire                  o_in_stall;
    wire                  o_out_valid;
    wire [COL_W-1:0]      o_out_column;
    wire [ROW_W-1:0]      o_out_row;
    wire [LEVEL_W-1:0]    o_level;
    wire [PATTERN_W-1:0]  o_pattern;
    wire                  o_over_level;
    wire                  o_last;
    wire                  o_cfg_ready;

    heat_map_scoreboard sb;
    bit                 quiet;
    bit                 frame_complete;
    int                 cur_low;

    thermal_grid_upscale_quantizer uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (in_op),
        .i_sample_index (in_sample_index),
        .i_temperature  (in_temperature),
        .i_column       (in_column),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_level        (o_level),
        .o_pattern      (o_pattern),
        .o_over_level   (o_over_level),
        .o_last         (o_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_valid && !o_in_stall) begin
            sb.note_request(in_op, in_sample_index, in_temperature, in_column);
        end
        if (rst_n && o_out_valid && !out_stall) begin
            sb.check_pixel(o_out_column, o_out_row, o_level, o_pattern, o_over_level,
                           o_last);
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 30);
    endfunction

    function automatic logic [10:0] pick_temp(int profile, int centre_q);
        int v;
        case (profile)
            0: return 11'($urandom_range(0, 2047));
            1: begin
                v = centre_q + int'($urandom_range(0, 96)) - 48;
                if (v > 1023) v = 1023;
                if (v < -1024) v = -1024;
                return 11'(v);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return 11'(-1024);
                    1: return 11'(1023);
                    2: return 11'(-1);
                    default: return 11'(0);
                endcase
            end
        endcase
    endfunction

    initial begin : out_backpressure
        int hold;
        forever begin
            @(posedge clk);
            if (quiet || $urandom_range(0, 1) == 0) begin
                out_stall <= 1'b0;
                hold = $urandom_range(1, 8);
            end else begin
                out_stall <= 1'b1;
                hold = idle_length();
                if (hold == 0) hold = 1;
            end
            repeat (hold - 1) @(posedge clk);
        end
    end

    task automatic push_request(logic op, logic [5:0] idx, logic [10:0] temp,
                                logic [3:0] col);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_op           <= op;
        in_sample_index <= idx;
        in_temperature  <= temp;
        in_column       <= col;
        in_valid        <= 1'b1;
        do @(posedge clk); while (o_in_stall);
    endtask

    task automatic load_sample(logic [5:0] idx, logic [10:0] temp);
        push_request(OP_LOAD, idx, temp, 4'($urandom_range(0, 15)));
    endtask

    task automatic render_column(logic [3:0] col);
        push_request(OP_RENDER, 6'($urandom_range(0, 63)), 11'($urandom_range(0, 2047)),
                     col);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_index idx, int value);
        cfg_index <= idx;
        cfg_data  <= 11'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!o_cfg_ready);
        sb.set_reg(idx, 11'(value));
    endtask

    task automatic apply_mapping(int low, int ceiling, int alert);
        wait_drained();
        write_reg(CFG_MAP_LOW, low);
        write_reg(CFG_MAP_HIGH_FLOOR, ceiling);
        write_reg(CFG_ALERT_LEVEL, alert);
        cfg_valid <= 1'b0;
        cur_low = low;
    endtask

    task automatic run_random(int budget);
        int sent;
        int r;
        int profile;
        int centre_q;
        int k;
        sent = 0;
        while (sent < budget) begin
            quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (!frame_complete || r < 55) begin
                profile = $urandom_range(0, 2);
                centre_q = cur_low * 4 + int'($urandom_range(0, 200)) - 40;
                for (int i = 0; i < CELLS; i++) begin
                    load_sample(6'(i), pick_temp(profile, centre_q));
                end
                frame_complete = 1'b1;
                k = $urandom_range(3, 8);
                for (int i = 0; i < k; i++) render_column(4'($urandom_range(0, 15)));
                sent += CELLS + k;
            end else if (r < 70) begin
                k = $urandom_range(1, 10);
                load_sample(6'd0, pick_temp(0, 0));
                for (int i = 0; i < k; i++) begin
                    load_sample(6'($urandom_range(0, 63)), pick_temp(0, 0));
                end
                render_column(4'($urandom_range(0, 15)));
                sent += k + 2;
            end else if (r < 85) begin
                k = $urandom_range(1, 5);
                for (int i = 0; i < k; i++) begin
                    load_sample(6'($urandom_range(1, 63)), pick_temp(0, 0));
                end
                sent += k;
            end else begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++) render_column(4'($urandom_range(0, 15)));
                sent += k;
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;
    endtask

    initial begin
        logic [10:0] first_col[8];
        logic [10:0] last_col[8];
        first_col = '{11'(-1024), 11'(1023), 11'(-1), 11'(0), 11'(3), 11'(4), 11'(7),
                      11'(100)};
        last_col  = '{11'(-4), 11'(80), 11'(96), 11'(97), 11'(1020), 11'(-1000), 11'(5),
                      11'(63)};
        sb              = new();
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_op           = OP_LOAD;
        in_sample_index = '0;
        in_temperature  = '0;
        in_column       = '0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_MAP_LOW;
        cfg_data        = '0;
        quiet           = 1'b0;
        frame_complete  = 1'b0;
        cur_low         = 20;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < GRID_WIDTH; i++) load_sample(6'(i), first_col[i]);
        load_sample(6'(CENTRE_COORD + CENTRE_COORD * GRID_WIDTH), 11'(128));
        render_column(4'd0);
        for (int i = 0; i < GRID_WIDTH; i++) begin
            load_sample(6'(GRID_LAST * GRID_WIDTH + i), last_col[i]);
        end
        render_column(4'd15);
        render_column(4'd14);
        load_sample(6'd0, 11'(-5));
        render_column(4'd0);
        in_valid <= 1'b0;

        apply_mapping(-256, 255, -1024);
        run_random(FRAME_ITEMS);
        apply_mapping(255, -255, 1023);
        run_random(FRAME_ITEMS);
        apply_mapping(0, 1, 0);
        run_random(FRAME_ITEMS);
        apply_mapping(int'($urandom_range(0, 511)) - 256, int'($urandom_range(0, 510)) - 255,
                      int'($urandom_range(0, 2047)) - 1024);
        run_random(FRAME_ITEMS);
        apply_mapping(-30, -100, -1);
        run_random(FRAME_ITEMS);

        wait_drained();
        if (sb.errors == 0) begin
            $display("[thermal_grid_upscale_quantizer] OK");
        end else begin
            $display("[thermal_grid_upscale_quantizer] ERROR");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("[thermal_grid_upscale_quantizer] ERROR");
        $finish;
    end

endmodule
